### rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types of the LCS-length similarity unit.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MAX_LEN = 256;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int SCORE_W = 9;
  localparam int SIM_W   = 17;
  localparam int DCNT_W  = $clog2(SIM_W + 1);

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN,
    ST_DIV
  } state_t;

endpackage

### rtl/core/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sequence_similarity_lcs_unit.sv
// A query symbol is written to the query memory while the unit stays idle; a subject symbol
// within MAX_LEN sweeps the score row, one cell per cycle through the row memory. On a last
// subject symbol follow the setup state ST_FIN and, unless both lengths are zero, the divider
// state ST_DIV; busy is high through all of this, low in the strobe cycle; one item at a time.
// Reset (rst_n, synchronous) clears the lengths, the overflow flags and marks the score row
// as cleared; the receiver cannot stall and takes each result in its strobe cycle.
// ----------------------------------------------------------------------------
// sequence_similarity_lcs_unit
// Longest-common-subsequence length of a stored query and a streamed subject,
// with the similarity score / longer length in unsigned Q1.16.
// ----------------------------------------------------------------------------
module sequence_similarity_lcs_unit import lcs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic               in_first,
  input  logic               in_last,
  output logic               out_valid,
  output logic [SCORE_W-1:0] out_score,
  output logic [SCORE_W-1:0] out_longer_length,
  output logic [SIM_W-1:0]   out_similarity,
  output logic               out_overflow
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  query_count_r, query_count_nxt;
  logic [CNT_W-1:0]  subject_count_r, subject_count_nxt;
  logic              overflow_seen_r, overflow_seen_nxt;
  logic              query_dropped_r, query_dropped_nxt;
  logic              row_clear_r, row_clear_nxt;
  logic [CNT_W-1:0]  last_score_r, last_score_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  diag_r, diag_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  divisor_r, divisor_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [SIM_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [SCORE_W-1:0] out_longer_r, out_longer_nxt;
  logic [SIM_W-1:0]   out_sim_r, out_sim_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic              accept;
  logic              in_sweep;
  logic              issue;
  logic              sweep_done;
  logic [CNT_W-1:0]  longer;
  logic              div_ge;

  logic              q_we;
  logic [ADDR_W-1:0] q_waddr;
  logic [SYM_W-1:0]  q_rdata;
  logic              row_we;
  logic [CNT_W-1:0]  row_wdata;
  logic [CNT_W-1:0]  row_rdata;

  logic [CNT_W-1:0]  qc_base;
  logic [CNT_W-1:0]  sc_base;
  logic [CNT_W-1:0]  up;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  best;
  logic [CNT_W:0]    diff;

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_symbol),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (q_rdata)
  );

  lcs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (wr_idx_r),
    .wdata (row_wdata),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (row_rdata)
  );

  always_comb begin
    busy     = (state_r != ST_IDLE);
    in_sweep = (state_r == ST_SWEEP);
  end

  assign accept     = start && !busy;
  assign issue      = (rd_idx_r < query_count_r);
  assign sweep_done = !issue && !pend_r;
  assign longer     = (query_count_r > subject_count_r) ? query_count_r : subject_count_r;
  assign div_ge     = (rem_r >= {1'b0, divisor_r});
  assign qc_base    = in_first ? '0 : query_count_r;
  assign sc_base    = in_first ? '0 : subject_count_r;

  always_comb begin
    up   = row_clear_r ? '0 : row_rdata;
    cand = diag_r + ((q_rdata == sym_r) ? CNT_W'(1) : CNT_W'(0));
    best = cand;
    if (best < up) begin
      best = up;
    end
    if (best < left_r) begin
      best = left_r;
    end
    diff = div_ge ? (rem_r - {1'b0, divisor_r}) : rem_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_SUBJECT) begin
          if (sc_base < CNT_W'(MAX_LEN)) begin
            state_nxt = ST_SWEEP;
          end else if (in_last) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        state_nxt = (longer == '0) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == DCNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    query_count_nxt   = query_count_r;
    subject_count_nxt = subject_count_r;
    overflow_seen_nxt = overflow_seen_r;
    query_dropped_nxt = query_dropped_r;
    row_clear_nxt     = row_clear_r;
    last_score_nxt    = last_score_r;
    sym_nxt           = sym_r;
    last_nxt          = last_r;
    rd_idx_nxt        = rd_idx_r;
    wr_idx_nxt        = wr_idx_r;
    pend_nxt          = pend_r;
    diag_nxt          = diag_r;
    left_nxt          = left_r;
    divisor_nxt       = divisor_r;
    rem_nxt           = rem_r;
    quo_nxt           = quo_r;
    div_cnt_nxt       = div_cnt_r;
    out_valid_nxt     = 1'b0;
    out_score_nxt     = out_score_r;
    out_longer_nxt    = out_longer_r;
    out_sim_nxt       = out_sim_r;
    out_ovf_nxt       = out_ovf_r;
    q_we              = 1'b0;
    q_waddr           = qc_base[ADDR_W-1:0];
    row_we            = 1'b0;
    row_wdata         = best;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_QUERY) begin
          if (in_first) begin
            query_dropped_nxt = 1'b0;
            overflow_seen_nxt = 1'b0;
          end
          row_clear_nxt     = 1'b1;
          subject_count_nxt = '0;
          last_score_nxt    = '0;
          if (qc_base < CNT_W'(MAX_LEN)) begin
            q_we            = 1'b1;
            query_count_nxt = qc_base + CNT_W'(1);
          end else begin
            query_count_nxt   = qc_base;
            query_dropped_nxt = 1'b1;
            overflow_seen_nxt = 1'b1;
          end
        end else if (accept) begin
          if (in_first) begin
            row_clear_nxt     = 1'b1;
            last_score_nxt    = '0;
            overflow_seen_nxt = query_dropped_r;
          end
          last_nxt = in_last;
          if (sc_base < CNT_W'(MAX_LEN)) begin
            subject_count_nxt = sc_base + CNT_W'(1);
            sym_nxt           = in_symbol;
            rd_idx_nxt        = '0;
            pend_nxt          = 1'b0;
            diag_nxt          = '0;
            left_nxt          = '0;
          end else begin
            subject_count_nxt = sc_base;
            overflow_seen_nxt = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          wr_idx_nxt = rd_idx_r[ADDR_W-1:0];
        end
        pend_nxt = issue;
        if (pend_r) begin
          row_we   = 1'b1;
          diag_nxt = up;
          left_nxt = best;
        end
        if (sweep_done) begin
          last_score_nxt = left_r;
          row_clear_nxt  = 1'b0;
        end
      end
      ST_FIN: begin
        out_score_nxt  = SCORE_W'(last_score_r);
        out_longer_nxt = SCORE_W'(longer);
        out_ovf_nxt    = overflow_seen_r;
        if (longer == '0) begin
          out_sim_nxt   = '0;
          out_valid_nxt = 1'b1;
        end else begin
          divisor_nxt = longer;
          rem_nxt     = {1'b0, last_score_r};
          quo_nxt     = '0;
          div_cnt_nxt = DCNT_W'(SIM_W);
        end
      end
      ST_DIV: begin
        quo_nxt     = {quo_r[SIM_W-2:0], div_ge};
        rem_nxt     = {diff[CNT_W-1:0], 1'b0};
        div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        if (div_cnt_r == DCNT_W'(1)) begin
          out_sim_nxt   = {quo_r[SIM_W-2:0], div_ge};
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      query_count_r   <= '0;
      subject_count_r <= '0;
      overflow_seen_r <= 1'b0;
      query_dropped_r <= 1'b0;
      row_clear_r     <= 1'b1;
      last_score_r    <= '0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      query_count_r   <= query_count_nxt;
      subject_count_r <= subject_count_nxt;
      overflow_seen_r <= overflow_seen_nxt;
      query_dropped_r <= query_dropped_nxt;
      row_clear_r     <= row_clear_nxt;
      last_score_r    <= last_score_nxt;
      pend_r          <= pend_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    diag_r       <= diag_nxt;
    left_r       <= left_nxt;
    divisor_r    <= divisor_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_score_r  <= out_score_nxt;
    out_longer_r <= out_longer_nxt;
    out_sim_r    <= out_sim_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_score         = out_score_r;
  assign out_longer_length = out_longer_r;
  assign out_similarity    = out_sim_r;
  assign out_overflow      = out_ovf_r;

`ifndef SYNTHESIS
  a_row_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (in_sweep && (CNT_W'(wr_idx_r) < query_count_r)))
    else $error("Score row written outside the query length.");

  a_score_le_longer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score <= out_longer_length))
    else $error("Score exceeds the longer length.");

  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_similarity <= SIM_W'(65536)))
    else $error("Similarity above 1.0.");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("Result strobe outside the end of a transaction.");
`endif

endmodule
